// ----- sv/pilp_pkg.sv -----
// Package for the prefixed integer literal parser.
// Holds the shared widths, character codes, radix codes and the structs
// passed between the classifier, the accumulator and the top level.
`default_nettype none

package pilp_pkg;

  localparam int unsigned CH_W    = 8;
  localparam int unsigned MAG_W   = 63;
  localparam int unsigned VALUE_W = 64;
  localparam int unsigned DIG_W   = 6;
  localparam int unsigned PROD_W  = MAG_W + 4;

  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CH_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CH_W-1:0] CH_0     = 8'h30;
  localparam logic [CH_W-1:0] CH_9     = 8'h39;
  localparam logic [CH_W-1:0] CH_UA    = 8'h41;
  localparam logic [CH_W-1:0] CH_UZ    = 8'h5A;
  localparam logic [CH_W-1:0] CH_LA    = 8'h61;
  localparam logic [CH_W-1:0] CH_LZ    = 8'h7A;
  localparam logic [CH_W-1:0] CH_UX    = 8'h58;
  localparam logic [CH_W-1:0] CH_LX    = 8'h78;
  localparam logic [CH_W-1:0] CH_UO    = 8'h4F;
  localparam logic [CH_W-1:0] CH_LO    = 8'h6F;
  localparam logic [CH_W-1:0] CH_UB    = 8'h42;
  localparam logic [CH_W-1:0] CH_LB    = 8'h62;

  // Offsets that map a letter onto its digit value (a/A -> 10).
  localparam logic [CH_W-1:0] LOWER_OFS = 8'd87;
  localparam logic [CH_W-1:0] UPPER_OFS = 8'd55;

  typedef enum logic [1:0] {
    RX_DEC = 2'd0,
    RX_HEX = 2'd1,
    RX_OCT = 2'd2,
    RX_BIN = 2'd3
  } radix_e;

  typedef struct packed {
    logic             is_ws;
    logic             is_sign;
    logic             is_minus;
    logic             is_zero;
    logic             is_x;
    logic             is_o;
    logic             is_b;
    logic             dig_ok;
    logic [DIG_W-1:0] dig;
  } char_cls_t;

  typedef struct packed {
    logic en;
    logic empty;
    logic last;
  } step_t;

endpackage

`default_nettype wire

// ----- sv/pilp_if.sv -----
// Valid/ready channel interfaces for the prefixed integer literal parser.
// Depends on pilp_pkg for payload widths.
`default_nettype none

interface pilp_in_if;
  logic                           valid;
  logic                           ready;
  logic [pilp_pkg::CH_W-1:0]      ch;
  logic                           is_empty;
  logic                           last;

  modport source (output valid, output ch, output is_empty, output last, input ready);
  modport sink   (input valid, input ch, input is_empty, input last, output ready);
endinterface

interface pilp_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [pilp_pkg::VALUE_W-1:0] value;
  logic                                ok;

  modport source (output valid, output value, output ok, input ready);
  modport sink   (input valid, input value, input ok, output ready);
endinterface

`default_nettype wire

// ----- sv/pilp_classify.sv -----
// Byte classifier: whitespace, sign, prefix letters and digit value.
// Purely combinational; depends on pilp_pkg.
`default_nettype none

module pilp_classify (
  input  wire logic [pilp_pkg::CH_W-1:0] ch_i,
  output pilp_pkg::char_cls_t            cls_o
);
  import pilp_pkg::*;

  logic [CH_W-1:0] num_v, low_v, up_v;
  logic            is_num, is_low, is_up;

  assign is_num = (ch_i >= CH_0)  && (ch_i <= CH_9);
  assign is_low = (ch_i >= CH_LA) && (ch_i <= CH_LZ);
  assign is_up  = (ch_i >= CH_UA) && (ch_i <= CH_UZ);
  assign num_v  = ch_i - CH_0;
  assign low_v  = ch_i - LOWER_OFS;
  assign up_v   = ch_i - UPPER_OFS;

  always_comb begin
    cls_o.is_ws    = (ch_i == CH_SPACE) || ((ch_i >= CH_TAB) && (ch_i <= CH_CR));
    cls_o.is_sign  = (ch_i == CH_PLUS) || (ch_i == CH_MINUS);
    cls_o.is_minus = (ch_i == CH_MINUS);
    cls_o.is_zero  = (ch_i == CH_0);
    cls_o.is_x     = (ch_i == CH_LX) || (ch_i == CH_UX);
    cls_o.is_o     = (ch_i == CH_LO) || (ch_i == CH_UO);
    cls_o.is_b     = (ch_i == CH_LB) || (ch_i == CH_UB);
    cls_o.dig_ok   = is_num || is_low || is_up;
    if (is_num) begin
      cls_o.dig = num_v[DIG_W-1:0];
    end else if (is_low) begin
      cls_o.dig = low_v[DIG_W-1:0];
    end else begin
      cls_o.dig = up_v[DIG_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ----- sv/pilp_accum.sv -----
// Parse state and accumulator: phase tracking, radix, sign, magnitude
// shift-add with overflow check, and the result of the finishing byte.
// Depends on pilp_pkg.
`default_nettype none

module pilp_accum (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire pilp_pkg::step_t                     step_i,
  input  wire pilp_pkg::char_cls_t                 cls_i,
  output logic signed [pilp_pkg::VALUE_W-1:0]      res_value_o,
  output logic                                     res_ok_o
);
  import pilp_pkg::*;

  typedef enum logic [2:0] {
    PH_LEAD   = 3'd0,
    PH_SIGN   = 3'd1,
    PH_ZERO   = 3'd2,
    PH_DIGITS = 3'd3,
    PH_TRAIL  = 3'd4
  } phase_e;

  phase_e            phase_q, phase_d;
  radix_e            radix_q, radix_d;
  logic              neg_q, neg_d;
  logic [MAG_W-1:0]  mag_q, mag_d;
  logic              zlead_q, zlead_d;
  logic              seen_q, seen_d;
  logic              failed_q, failed_d;

  logic [PROD_W-1:0] mag_ext, prod, sum;
  logic [DIG_W-1:0]  rad_v;
  logic              dig_bad, sign_path, take_dig;
  logic [VALUE_W-1:0] mag_val;

  // Shift-add for the active radix; the top four bits flag overflow.
  assign mag_ext = {4'b0, mag_q};
  always_comb begin
    case (radix_q)
      RX_DEC:  begin prod = (mag_ext << 3) + (mag_ext << 1); rad_v = 6'd10; end
      RX_HEX:  begin prod = mag_ext << 4;                    rad_v = 6'd16; end
      RX_OCT:  begin prod = mag_ext << 3;                    rad_v = 6'd8;  end
      RX_BIN:  begin prod = mag_ext << 1;                    rad_v = 6'd2;  end
      default: begin prod = mag_ext << 1;                    rad_v = 6'd2;  end
    endcase
  end
  assign sum = prod + {{(PROD_W-DIG_W){1'b0}}, cls_i.dig};
  assign dig_bad = !cls_i.dig_ok || (cls_i.dig >= rad_v) ||
                   (zlead_q && (cls_i.dig != '0)) || (|sum[PROD_W-1:MAG_W]);

  always_comb begin
    phase_d   = phase_q;
    radix_d   = radix_q;
    neg_d     = neg_q;
    mag_d     = mag_q;
    zlead_d   = zlead_q;
    seen_d    = seen_q;
    failed_d  = failed_q;
    sign_path = 1'b0;
    take_dig  = 1'b0;
    if (step_i.en && !step_i.empty && !failed_q) begin
      case (phase_q)
        PH_LEAD: begin
          if (cls_i.is_sign) begin
            neg_d   = cls_i.is_minus;
            phase_d = PH_SIGN;
          end else if (!cls_i.is_ws) begin
            sign_path = 1'b1;
          end
        end
        PH_SIGN: begin
          sign_path = 1'b1;
        end
        PH_ZERO: begin
          if (cls_i.is_ws) begin
            phase_d = PH_TRAIL;
          end else if (cls_i.is_x || cls_i.is_o || cls_i.is_b) begin
            radix_d = cls_i.is_x ? RX_HEX : (cls_i.is_o ? RX_OCT : RX_BIN);
            phase_d = PH_DIGITS;
            seen_d  = 1'b0;
          end else if (cls_i.is_zero) begin
            phase_d = PH_DIGITS;
            zlead_d = 1'b1;
          end else begin
            failed_d = 1'b1;
          end
        end
        PH_DIGITS: begin
          if (cls_i.is_ws) begin
            phase_d = PH_TRAIL;
          end else begin
            take_dig = 1'b1;
          end
        end
        default: begin
          if (!cls_i.is_ws) begin
            failed_d = 1'b1;
          end
        end
      endcase
      // First character of the number proper.
      if (sign_path) begin
        if (cls_i.is_zero) begin
          phase_d = PH_ZERO;
          seen_d  = 1'b1;
        end else begin
          phase_d  = PH_DIGITS;
          radix_d  = RX_DEC;
          take_dig = 1'b1;
        end
      end
      if (take_dig) begin
        if (dig_bad) begin
          failed_d = 1'b1;
        end else begin
          mag_d  = sum[MAG_W-1:0];
          seen_d = 1'b1;
        end
      end
    end
  end

  assign mag_val     = {1'b0, mag_d};
  assign res_ok_o    = !failed_d && seen_d;
  assign res_value_o = !res_ok_o ? '0 :
                       (neg_d ? $signed(VALUE_W'(0) - mag_val) : $signed(mag_val));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_LEAD;
      radix_q  <= RX_DEC;
      neg_q    <= 1'b0;
      mag_q    <= '0;
      zlead_q  <= 1'b0;
      seen_q   <= 1'b0;
      failed_q <= 1'b0;
    end else if (step_i.en) begin
      if (step_i.last) begin
        // Text done: start the next one clean.
        phase_q  <= PH_LEAD;
        radix_q  <= RX_DEC;
        neg_q    <= 1'b0;
        mag_q    <= '0;
        zlead_q  <= 1'b0;
        seen_q   <= 1'b0;
        failed_q <= 1'b0;
      end else begin
        phase_q  <= phase_d;
        radix_q  <= radix_d;
        neg_q    <= neg_d;
        mag_q    <= mag_d;
        zlead_q  <= zlead_d;
        seen_q   <= seen_d;
        failed_q <= failed_d;
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/prefixed_integer_literal_parser_core.sv -----
// Prefixed integer literal parser, top level.
// Depends on pilp_pkg, pilp_if, pilp_classify and pilp_accum.
//
// Usage:
//   in_chan_i carries the text one byte per transfer (ch), with last on the
//   final byte and is_empty for an item that holds no byte (an empty text is
//   a single is_empty item with last set). out_chan_o gives one transfer per
//   text, on its last item: the signed value and ok (value is 0 when ok is 0).
//   Whitespace, optional sign, 0x/0o/0b prefix and decimal are accepted; a
//   magnitude above 2^63-1 gives ok 0.
// Timing:
//   One byte per cycle sustained, except while a last byte waits on the
//   result register (see Stall). A byte is held in the input register
//   while the classifier and the accumulator shift-add run on it; the
//   result register then loads the result of the last byte.
// Reset:
//   rst_ni clears the input and output valid flags and the parse state;
//   the next byte starts a new text.
// Stall:
//   While out_chan_o holds a result that is not taken, non-last bytes keep
//   flowing; a last byte waits in the input register and in_chan_i.ready
//   drops until the result register frees up.
`default_nettype none

module prefixed_integer_literal_parser_core (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  pilp_in_if.sink     in_chan_i,
  pilp_out_if.source  out_chan_o
);
  import pilp_pkg::*;

  logic                      s1_valid_q;
  logic [CH_W-1:0]           s1_ch_q;
  logic                      s1_empty_q;
  logic                      s1_last_q;
  logic                      s1_go, out_free, in_fire;

  logic                      out_valid_q;
  logic signed [VALUE_W-1:0] out_value_q;
  logic                      out_ok_q;

  char_cls_t                 cls;
  step_t                     step;
  logic signed [VALUE_W-1:0] res_value;
  logic                      res_ok;

  assign out_free        = !out_valid_q || out_chan_o.ready;
  assign s1_go           = s1_valid_q && (!s1_last_q || out_free);
  assign in_chan_i.ready = !s1_valid_q || s1_go;
  assign in_fire         = in_chan_i.valid && in_chan_i.ready;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_chan_i.ready) begin
      s1_valid_q <= in_chan_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_ch_q    <= in_chan_i.ch;
      s1_empty_q <= in_chan_i.is_empty;
      s1_last_q  <= in_chan_i.last;
    end
  end

  pilp_classify u_classify (
    .ch_i  (s1_ch_q),
    .cls_o (cls)
  );

  assign step.en    = s1_go;
  assign step.empty = s1_empty_q;
  assign step.last  = s1_last_q;

  pilp_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .cls_i       (cls),
    .res_value_o (res_value),
    .res_ok_o    (res_ok)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_go && s1_last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_chan_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && s1_last_q) begin
      out_value_q <= res_value;
      out_ok_q    <= res_ok;
    end
  end

  assign out_chan_o.valid = out_valid_q;
  assign out_chan_o.value = out_value_q;
  assign out_chan_o.ok    = out_ok_q;

  a_last_loads_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_go && s1_last_q) |=> out_valid_q)
    else $error("finished text did not produce a result");

  a_fail_zero_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ok_q) |-> (out_value_q == '0))
    else $error("rejected literal carries a nonzero value");

  a_ok_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_ok_q) |-> (!out_value_q[VALUE_W-1] || (out_value_q[VALUE_W-2:0] != '0)))
    else $error("accepted value outside the 63-bit magnitude range");

  a_last_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_last_q && !out_free) |-> !in_chan_i.ready)
    else $error("input taken while a last byte is blocked");

endmodule

`default_nettype wire
